// ----- design/bdq_pkg.sv -----
// Package with the shared types and constants of the bounded deque engine.
`default_nettype none
package bdq_pkg;
    localparam int CAPACITY = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W = SLOT_W + 1;
    localparam int VALUE_W = 32;
    localparam int POS_W = 11;
    localparam int OP_W = 4;
    localparam int ST_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_TAIL  = 4'd0;
    localparam logic [OP_W-1:0] OP_PUSH_HEAD  = 4'd1;
    localparam logic [OP_W-1:0] OP_POP_TAIL   = 4'd2;
    localparam logic [OP_W-1:0] OP_POP_HEAD   = 4'd3;
    localparam logic [OP_W-1:0] OP_READ_AT    = 4'd4;
    localparam logic [OP_W-1:0] OP_INSERT_AT  = 4'd5;
    localparam logic [OP_W-1:0] OP_ERASE_AT   = 4'd6;
    localparam logic [OP_W-1:0] OP_READ_FRONT = 4'd7;
    localparam logic [OP_W-1:0] OP_READ_BACK  = 4'd8;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
    } t_cmd;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [ST_W-1:0]    status;
        logic [POS_W-1:0]   element_count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_SHIFT_RD, S_SHIFT_WR, S_FINAL, S_OUT
    } t_state;
endpackage
`default_nettype wire

// ----- design/bdq_if.sv -----
// Valid/ready channel interface used for commands and responses.
`default_nettype none
interface bdq_cmd_if;
    logic           valid;
    logic           ready;
    bdq_pkg::t_cmd  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bdq_rsp_if;
    logic           valid;
    logic           ready;
    bdq_pkg::t_rsp  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/bdq_front.sv -----
// Front end: accepts command beats into a short queue for the back end.
`default_nettype none
module bdq_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    bdq_cmd_if.sink         cmd,
    output logic            o_q_valid,
    output bdq_pkg::t_cmd   o_q_cmd,
    input  wire             i_q_pop
);
    bdq_pkg::t_cmd r_q [bdq_pkg::QDEPTH];
    logic r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic push;

    assign cmd.ready = (r_cnt != 2'(bdq_pkg::QDEPTH));
    assign push = cmd.valid && cmd.ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd = r_q[r_rp];

    always_comb begin
        n_wp = push ? ~r_wp : r_wp;
        n_rp = i_q_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) r_q[r_wp] <= cmd.payload;
    end
endmodule
`default_nettype wire

// ----- design/bdq_back.sv -----
// Back end: carries out deque operations on the ring buffer memory.
`default_nettype none
module bdq_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_q_valid,
    input  bdq_pkg::t_cmd   i_q_cmd,
    output logic            o_q_pop,
    bdq_rsp_if.source       rsp
);
    localparam int SW = bdq_pkg::SLOT_W;
    localparam int CW = bdq_pkg::CNT_W;

    // Classes of work for the command at the head of the queue.
    localparam logic [1:0] K_DIRECT = 2'd0;
    localparam logic [1:0] K_READ   = 2'd1;
    localparam logic [1:0] K_SHIFT  = 2'd2;

    logic [bdq_pkg::DATA_WIDTH-1:0] r_mem [bdq_pkg::CAPACITY];
    logic [bdq_pkg::DATA_WIDTH-1:0] r_rdata;

    bdq_pkg::t_state r_state, n_state;
    bdq_pkg::t_cmd   r_cmd;
    logic [SW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   pos;
    bdq_pkg::t_rsp   r_rsp, n_rsp;

    logic            mem_we, mem_re;
    logic [SW-1:0]   mem_waddr, mem_raddr;
    logic [bdq_pkg::DATA_WIDTH-1:0] mem_wdata;

    logic full, empty;
    logic [1:0] kind;  // direct, read then respond, or shift
    logic [bdq_pkg::ST_W-1:0] st;

    function automatic logic [SW-1:0] slot(input logic [SW-1:0] h, input logic [CW-1:0] i);
        slot = h + i[SW-1:0];
    endfunction

    assign pos = i_q_cmd.position[CW-1:0];
    assign full = (r_count == CW'(bdq_pkg::CAPACITY));
    assign empty = (r_count == '0);
    assign rsp.valid = (r_state == bdq_pkg::S_OUT);
    assign rsp.payload = r_rsp;
    assign o_q_pop = (r_state == bdq_pkg::S_IDLE) && i_q_valid;

    // Classify the command at the head of the queue.
    always_comb begin
        st = bdq_pkg::ST_OK;
        kind = K_DIRECT;
        unique case (i_q_cmd.opcode)
            bdq_pkg::OP_PUSH_TAIL, bdq_pkg::OP_PUSH_HEAD:
                if (full) st = bdq_pkg::ST_FULL;
            bdq_pkg::OP_POP_TAIL, bdq_pkg::OP_POP_HEAD,
            bdq_pkg::OP_READ_FRONT, bdq_pkg::OP_READ_BACK: begin
                if (empty) st = bdq_pkg::ST_EMPTY;
                else kind = K_READ;
            end
            bdq_pkg::OP_READ_AT: begin
                if (i_q_cmd.position >= bdq_pkg::POS_W'(r_count)) st = bdq_pkg::ST_RANGE;
                else kind = K_READ;
            end
            bdq_pkg::OP_INSERT_AT: begin
                if (i_q_cmd.position > bdq_pkg::POS_W'(r_count)) st = bdq_pkg::ST_RANGE;
                else if (full) st = bdq_pkg::ST_FULL;
                else kind = K_SHIFT;
            end
            bdq_pkg::OP_ERASE_AT: begin
                if (i_q_cmd.position > bdq_pkg::POS_W'(r_count)) st = bdq_pkg::ST_RANGE;
                else if (i_q_cmd.position != bdq_pkg::POS_W'(r_count)) kind = K_SHIFT;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bdq_pkg::S_IDLE:
                if (i_q_valid) begin
                    if (kind == K_READ) n_state = bdq_pkg::S_RD;
                    else if (kind == K_SHIFT) n_state = bdq_pkg::S_SHIFT_RD;
                    else n_state = bdq_pkg::S_OUT;
                end
            bdq_pkg::S_RD:       n_state = bdq_pkg::S_OUT;
            bdq_pkg::S_SHIFT_RD: begin
                if (r_cmd.opcode == bdq_pkg::OP_INSERT_AT)
                    n_state = (r_idx == CW'(r_cmd.position)) ? bdq_pkg::S_FINAL
                                                            : bdq_pkg::S_SHIFT_WR;
                else
                    n_state = (r_idx + CW'(1) >= r_count) ? bdq_pkg::S_FINAL
                                                         : bdq_pkg::S_SHIFT_WR;
            end
            bdq_pkg::S_SHIFT_WR: n_state = bdq_pkg::S_SHIFT_RD;
            bdq_pkg::S_FINAL:    n_state = bdq_pkg::S_OUT;
            bdq_pkg::S_OUT:      if (rsp.ready) n_state = bdq_pkg::S_IDLE;
            default:             n_state = bdq_pkg::S_IDLE;
        endcase
    end

    // Memory access, pointer and response updates.
    always_comb begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_waddr = '0;
        mem_raddr = '0;
        mem_wdata = r_cmd.value[bdq_pkg::DATA_WIDTH-1:0];
        n_head = r_head;
        n_count = r_count;
        n_idx = r_idx;
        n_rsp = r_rsp;
        unique case (r_state)
            bdq_pkg::S_IDLE: if (i_q_valid) begin
                n_rsp.read_value = '0;
                n_rsp.status = st;
                n_rsp.element_count = bdq_pkg::POS_W'(r_count);
                mem_raddr = slot(r_head, r_count - CW'(1));
                if (i_q_cmd.opcode == bdq_pkg::OP_POP_HEAD ||
                    i_q_cmd.opcode == bdq_pkg::OP_READ_FRONT)
                    mem_raddr = r_head;
                else if (i_q_cmd.opcode == bdq_pkg::OP_READ_AT)
                    mem_raddr = slot(r_head, pos);
                mem_re = (kind == K_READ);
                if (st == bdq_pkg::ST_OK) begin
                    if (i_q_cmd.opcode == bdq_pkg::OP_PUSH_TAIL) begin
                        mem_we = 1'b1;
                        mem_waddr = slot(r_head, r_count);
                        mem_wdata = i_q_cmd.value[bdq_pkg::DATA_WIDTH-1:0];
                        n_count = r_count + CW'(1);
                    end else if (i_q_cmd.opcode == bdq_pkg::OP_PUSH_HEAD) begin
                        mem_we = 1'b1;
                        mem_waddr = r_head - SW'(1);
                        mem_wdata = i_q_cmd.value[bdq_pkg::DATA_WIDTH-1:0];
                        n_head = r_head - SW'(1);
                        n_count = r_count + CW'(1);
                    end else if (i_q_cmd.opcode == bdq_pkg::OP_POP_TAIL) begin
                        n_count = r_count - CW'(1);
                    end else if (i_q_cmd.opcode == bdq_pkg::OP_POP_HEAD) begin
                        n_head = r_head + SW'(1);
                        n_count = r_count - CW'(1);
                    end
                    n_rsp.element_count = bdq_pkg::POS_W'(n_count);
                end
                if (i_q_cmd.opcode == bdq_pkg::OP_INSERT_AT) n_idx = r_count;
                else n_idx = pos;
                if (kind == K_SHIFT) begin
                    // Shift reads the neighbor of the current index first.
                    mem_re = 1'b1;
                    if (i_q_cmd.opcode == bdq_pkg::OP_INSERT_AT)
                        mem_raddr = slot(r_head, r_count - CW'(1));
                    else
                        mem_raddr = slot(r_head, pos + CW'(1));
                end
            end
            bdq_pkg::S_RD: n_rsp.read_value = 32'(r_rdata);
            bdq_pkg::S_SHIFT_RD: ;
            bdq_pkg::S_SHIFT_WR: begin
                // Data of the neighbor is in r_rdata: move it into the index slot.
                mem_we = 1'b1;
                mem_waddr = slot(r_head, r_idx);
                mem_wdata = r_rdata;
                mem_re = 1'b1;
                if (r_cmd.opcode == bdq_pkg::OP_INSERT_AT) begin
                    n_idx = r_idx - CW'(1);
                    mem_raddr = slot(r_head, r_idx - CW'(2));
                end else begin
                    n_idx = r_idx + CW'(1);
                    mem_raddr = slot(r_head, r_idx + CW'(2));
                end
            end
            bdq_pkg::S_FINAL: begin
                if (r_cmd.opcode == bdq_pkg::OP_INSERT_AT) begin
                    mem_we = 1'b1;
                    mem_waddr = slot(r_head, r_idx);
                    n_count = r_count + CW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                end
                n_rsp.element_count = bdq_pkg::POS_W'(n_count);
            end
            bdq_pkg::S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdq_pkg::S_IDLE;
            r_head <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head <= n_head;
            r_count <= n_count;
        end
        r_idx <= n_idx;
        r_rsp <= n_rsp;
        if (o_q_pop) r_cmd <= i_q_cmd;
    end

    // The shift write in S_SHIFT_WR uses r_rdata from the read issued before S_SHIFT_RD,
    // so the extra S_SHIFT_RD state absorbs the registered read latency.
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end
endmodule
`default_nettype wire

// ----- design/bounded_deque_engine.sv -----
// Top level of the bounded deque engine: command queue and execution back end.
// Pushes and error statuses go from idle straight to the response state; pops and reads
// pass through one registered memory read first; insert and erase move the elements one
// at a time through a read state and a write state, then a final state before the response.
// The back end takes the next queued command only after the response beat is accepted.
// Reset (i_rst_n, synchronous, active low) empties the deque and the command queue.
`default_nettype none
module bounded_deque_engine (
    input  wire       i_clk,
    input  wire       i_rst_n,
    bdq_cmd_if.sink   cmd,
    bdq_rsp_if.source rsp
);
    // The front end buffers up to two command beats, so the sender is held up
    // while the back end finishes a long shift only once that queue is full.
    logic          q_valid;
    bdq_pkg::t_cmd q_cmd;
    logic          q_pop;

    bdq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cmd(cmd),
        .o_q_valid(q_valid), .o_q_cmd(q_cmd), .i_q_pop(q_pop)
    );

    // The back end owns the ring memory, the head slot and the element count.
    bdq_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_cmd(q_cmd), .o_q_pop(q_pop), .rsp(rsp)
    );

`ifndef SYNTHESIS
    // The back end never pulls from an empty command queue.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop from empty command queue");
    // A response never claims more elements than the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid |-> (rsp.payload.element_count <= 11'(bdq_pkg::CAPACITY)))
        else $error("element count above capacity");
    // Non-ok responses carry a zero read value.
    a_zero_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp.valid && rsp.payload.status != bdq_pkg::ST_OK) |->
        (rsp.payload.read_value == '0)) else $error("nonzero value on error");
`endif
endmodule
`default_nettype wire

// ----- tb/sv/bdq_checker.sv -----
// Checker that watches the command and response channels and predicts each response.
module bdq_checker
    import bdq_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    bdq_cmd_if.sink    cmd,
    bdq_rsp_if.source  rsp,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_rsp_seen
);
    // Model of the deque kept as a plain queue of words in logical order.
    logic [VALUE_W-1:0] deque_words[$];
    t_rsp               expected_rsp[$];

    function automatic t_rsp apply_op(input t_cmd c);
        t_rsp r;
        r = '0;
        r.status = ST_OK;
        case (c.opcode)
            OP_PUSH_TAIL, OP_PUSH_HEAD: begin
                if (deque_words.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (c.opcode == OP_PUSH_TAIL) begin
                    deque_words.insert(deque_words.size(), c.value);
                end else begin
                    deque_words.insert(0, c.value);
                end
            end
            OP_POP_TAIL, OP_POP_HEAD, OP_READ_FRONT, OP_READ_BACK: begin
                if (deque_words.size() == 0) begin
                    r.status = ST_EMPTY;
                end else if (c.opcode == OP_POP_TAIL) begin
                    r.read_value = deque_words[deque_words.size()-1];
                    deque_words.delete(deque_words.size()-1);
                end else if (c.opcode == OP_POP_HEAD) begin
                    r.read_value = deque_words[0];
                    deque_words.delete(0);
                end else if (c.opcode == OP_READ_FRONT) begin
                    r.read_value = deque_words[0];
                end else begin
                    r.read_value = deque_words[deque_words.size()-1];
                end
            end
            OP_READ_AT: begin
                if (c.position >= deque_words.size()) r.status = ST_RANGE;
                else r.read_value = deque_words[c.position];
            end
            OP_INSERT_AT: begin
                if (c.position > deque_words.size()) r.status = ST_RANGE;
                else if (deque_words.size() >= CAPACITY) r.status = ST_FULL;
                else deque_words.insert(c.position, c.value);
            end
            OP_ERASE_AT: begin
                if (c.position > deque_words.size()) r.status = ST_RANGE;
                else if (c.position < deque_words.size()) deque_words.delete(c.position);
            end
            default: ;
        endcase
        r.element_count = POS_W'(deque_words.size());
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        int   errs;
        errs = 0;
        if (!i_rst_n) begin
            deque_words.delete();
            expected_rsp.delete();
        end else begin
            if (cmd.valid && cmd.ready)
                expected_rsp.insert(expected_rsp.size(), apply_op(cmd.payload));
            if (rsp.valid && rsp.ready) begin
                o_rsp_seen <= o_rsp_seen + 1;
                if (expected_rsp.size() == 0) begin
                    $error("response beat with nothing expected");
                    errs++;
                end else begin
                    want = expected_rsp[0];
                    expected_rsp.delete(0);
                    if (rsp.payload.read_value !== want.read_value) begin
                        $error("read_value: expected %h, got %h",
                               want.read_value, rsp.payload.read_value);
                        errs++;
                    end
                    if (rsp.payload.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, rsp.payload.status);
                        errs++;
                    end
                    if (rsp.payload.element_count !== want.element_count) begin
                        $error("element_count: expected %0d, got %0d",
                               want.element_count, rsp.payload.element_count);
                        errs++;
                    end
                end
            end
        end
        if (errs != 0) o_fail_count <= o_fail_count + errs;
        o_pending <= expected_rsp.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_rsp_seen = 0;
    end
endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top: drives deque operations with bursty timing and gives the verdict.
module tb_top;
    import bdq_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   rsp_seen;
    int   beats_sent;
    int   full_hits;

    bdq_cmd_if cmd_ch ();
    bdq_rsp_if rsp_ch ();

    bounded_deque_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cmd     (cmd_ch.sink),
        .rsp     (rsp_ch.source)
    );

    bdq_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cmd          (cmd_ch.sink),
        .rsp          (rsp_ch.source),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_rsp_seen   (rsp_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The receiver stalls on its own pattern: long ready stretches, then
    // random stall phases, so back pressure lands on every phase of the engine.
    initial begin
        int phase;
        rsp_ch.ready = 1'b0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if ((phase / 300) % 3 == 0) rsp_ch.ready <= 1'b1;
            else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Shadow count of elements, kept here only to steer the stimulus toward
    // interesting fill levels; the checker holds the real prediction.
    int shadow_count;

    // Sends one beat and holds it until accepted. The sender keeps valid high
    // across back-to-back beats and lowers it only when a gap follows.
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val,
                             input logic [POS_W-1:0] pos, input bit gap_after);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= '{opcode: op, value: val, position: pos};
        do @(posedge i_clk); while (!cmd_ch.ready);
        beats_sent++;
        case (op)
            OP_PUSH_TAIL, OP_PUSH_HEAD: if (shadow_count < CAPACITY) shadow_count++;
                else full_hits++;
            OP_INSERT_AT: if (pos <= shadow_count) begin
                if (shadow_count < CAPACITY) shadow_count++;
                else full_hits++;
            end
            OP_POP_TAIL, OP_POP_HEAD: if (shadow_count > 0) shadow_count--;
            OP_ERASE_AT: if (pos < shadow_count) shadow_count--;
            default: ;
        endcase
        @(negedge i_clk);
        if (gap_after) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    // Burst bookkeeping: random burst length, then a random gap after about half of the bursts.
    int burst_left;
    task automatic send_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val,
                           input logic [POS_W-1:0] pos);
        bit gap;
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left--;
        gap = (burst_left == 0) && ($urandom_range(0, 1) == 1);
        send_beat(op, val, pos, gap);
    endtask

    function automatic logic [POS_W-1:0] pick_pos(input int slack);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return POS_W'($urandom_range(0, 2047));
        if (r == 1) return POS_W'(shadow_count + slack);
        if (r == 2) return POS_W'(shadow_count);
        if (shadow_count == 0) return '0;
        return POS_W'($urandom_range(0, shadow_count - 1));
    endfunction

    initial begin
        int mode;
        int k;
        i_rst_n        = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        beats_sent     = 0;
        full_hits      = 0;
        shadow_count   = 0;
        burst_left     = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: empty errors, range errors, extremes and every opcode.
        send_op(OP_POP_TAIL, '0, '0);
        send_op(OP_POP_HEAD, '0, '0);
        send_op(OP_READ_FRONT, '0, '0);
        send_op(OP_READ_BACK, '0, '0);
        send_op(OP_READ_AT, '0, '0);
        send_op(OP_ERASE_AT, '0, '0);
        send_op(OP_ERASE_AT, '0, 11'd1);
        send_op(OP_INSERT_AT, 32'h1234_5678, 11'd1);
        send_op(OP_INSERT_AT, 32'hFFFF_FFFF, 11'd0);
        send_op(OP_PUSH_TAIL, 32'h0000_0000, '0);
        send_op(OP_PUSH_HEAD, 32'hAAAA_5555, 11'h7FF);
        send_op(OP_INSERT_AT, 32'h5555_AAAA, 11'd3);
        send_op(OP_INSERT_AT, 32'h0F0F_F0F0, 11'd1);
        send_op(OP_READ_AT, '0, 11'd3);
        send_op(OP_READ_AT, '0, 11'd4);
        send_op(OP_READ_AT, '0, 11'h7FF);
        send_op(OP_READ_FRONT, '0, '0);
        send_op(OP_READ_BACK, '0, '0);
        send_op(OP_ERASE_AT, '0, 11'd4);
        send_op(OP_ERASE_AT, '0, 11'd5);
        send_op(OP_ERASE_AT, '0, 11'd1);
        send_op(4'd9, 32'hDEAD_BEEF, 11'd2);
        send_op(4'd15, 32'hFFFF_FFFF, 11'h7FF);
        send_op(OP_POP_HEAD, '0, '0);
        send_op(OP_POP_TAIL, '0, '0);

        // Random part. Phases steer the fill level: grow, churn, one fill to
        // capacity so the full status is hit, then churn and shrink from the top.
        // Inserts and erases are mostly near the back to keep the shifting cost bounded.
        for (int ph = 0; ph < 5; ph++) begin
            mode = (ph == 4) ? 2 : ph % 4;
            if (ph == 2) begin
                // Fill to capacity with cheap pushes, then poke the full cases.
                while (shadow_count < CAPACITY)
                    send_op($urandom_range(0, 1) ? OP_PUSH_TAIL : OP_PUSH_HEAD,
                            $urandom, '0);
                send_op(OP_PUSH_TAIL, $urandom, '0);
                send_op(OP_PUSH_HEAD, $urandom, '0);
                send_op(OP_INSERT_AT, $urandom, 11'd1024);
                send_op(OP_INSERT_AT, $urandom, 11'd1025);
                send_op(OP_READ_AT, '0, 11'd1023);
                send_op(OP_READ_AT, '0, 11'd1024);
                send_op(OP_ERASE_AT, '0, 11'd1024);
                send_op(OP_ERASE_AT, '0, 11'd1023);
                send_op(OP_INSERT_AT, $urandom, 11'd1023);
                continue;
            end
            for (k = 0; k < 100; k++) begin
                logic [OP_W-1:0] op;
                logic [POS_W-1:0] pos;
                int r;
                r = $urandom_range(0, 99);
                if (r < 3) op = OP_W'($urandom_range(9, 15));
                else if (mode == 0) op = (r < 60) ? OP_W'($urandom_range(0, 1))
                                                  : OP_W'($urandom_range(2, 8));
                else if (mode == 2) op = (r < 55) ? OP_W'($urandom_range(2, 3))
                                                  : OP_W'($urandom_range(0, 8));
                else op = OP_W'($urandom_range(0, 8));
                pos = pick_pos($urandom_range(0, 1));
                // Keep shifts short on big deques: aim inserts and erases near the back.
                if ((op == OP_INSERT_AT || op == OP_ERASE_AT) && shadow_count > 40 &&
                    pos < shadow_count - 20 && $urandom_range(0, 3) != 0)
                    pos = POS_W'(shadow_count - $urandom_range(0, 20));
                send_op(op, $urandom, pos);
            end
        end
        cmd_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        $display("Sent %0d operation beats, checked %0d responses, full deque reached %0d times.",
                 beats_sent, rsp_seen, full_hits);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Run timed out.");
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/bdq_pkg.sv
design/bdq_if.sv
design/bdq_front.sv
design/bdq_back.sv
design/bounded_deque_engine.sv
tb/sv/bdq_checker.sv
tb/sv/tb_top.sv
